### rtl/salc_pkg.sv
//------------------------------------------------------------------------------
// salc_pkg: shared types and constants
// Opcodes, register indexes, counter indexes and the control/status structs
// between the cache controller and its datapath.
//------------------------------------------------------------------------------
`default_nettype none
package salc_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 4;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 264;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_SPLIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SETS0  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SETS1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WBACK  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WALLOC = 3'd6;

   localparam int unsigned C_IACC  = 0;
   localparam int unsigned C_IMISS = 1;
   localparam int unsigned C_IREPL = 2;
   localparam int unsigned C_DACC  = 3;
   localparam int unsigned C_DMISS = 4;
   localparam int unsigned C_DREPL = 5;
   localparam int unsigned C_FETCH = 6;
   localparam int unsigned C_COPY  = 7;
   localparam int unsigned N_CNT   = 8;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, start set read
      logic lookup;    // compare tags on read data
      logic update;    // write set and bump counters
      logic sweep;     // clear one set (flush or clear pass)
      logic sweep_cnt; // count dirty lines during flush sweep
      logic sweep_rst; // reset sweep pointer
      logic capture;   // load the result register
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_done;
   } stat_type;

endpackage
`default_nettype wire

### rtl/salc_ctrl.sv
//------------------------------------------------------------------------------
// salc_ctrl: cache controller
// Sequences lookup, update and sweeps; owns the handshakes.
//------------------------------------------------------------------------------
`default_nettype none
module salc_ctrl
   import salc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_fire,
   input  wire logic     req_flush,
   input  wire logic     cfg_fire,
   input  wire logic     rsp_taken,
   input  wire stat_type stat,
   output logic          req_ready,
   output logic          rsp_valid,
   output ctrl_type      ctrl
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_UPD, S_FLUSH, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      dirty_ff, dirty_in; // clear pass pending after config write

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      dirty_in     = dirty_ff | cfg_fire;
      ctrl         = '0;
      if (rsp_valid_ff && rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            ctrl.sweep = 1'b1;
            if (stat.sweep_done) begin
               ctrl.sweep_rst = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_IDLE: begin
            if (dirty_ff) begin
               dirty_in       = cfg_fire;
               ctrl.sweep_rst = 1'b1;
               state_in       = S_CLEAR;
            end else if (req_fire) begin
               ctrl.load = 1'b1;
               state_in  = req_flush ? S_FLUSH : S_LOOK;
            end
         end
         S_LOOK: begin
            ctrl.lookup = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            ctrl.update = 1'b1;
            state_in    = S_RESP;
         end
         S_FLUSH: begin
            ctrl.sweep     = 1'b1;
            ctrl.sweep_cnt = 1'b1;
            if (stat.sweep_done) begin
               ctrl.sweep_rst = 1'b1;
               state_in       = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_taken) begin
               ctrl.capture = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) && !dirty_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         dirty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dirty_ff     <= dirty_in;
      end
   end

endmodule
`default_nettype wire

### rtl/salc_dpath.sv
//------------------------------------------------------------------------------
// salc_dpath: cache datapath
// Set memories, tag compare, LRU update, configuration and counters.
//------------------------------------------------------------------------------
`default_nettype none
module salc_dpath
   import salc_pkg::*;
#(
   parameter int unsigned MAX_WAYS   = 8,
   parameter int unsigned MAX_SETS   = 1024,
   parameter int unsigned WORD_BYTES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_type              ctrl,
   output stat_type                   stat,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  csr_fire,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_value,
   output logic [RSP_DATA_W-1:0]      rsp_data
);

   localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned RANK_W = $clog2(MAX_WAYS + 1);
   localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int unsigned SL_MAX = $clog2(MAX_SETS + 1) - 1;
   localparam int unsigned ROWS   = 2 * MAX_SETS;
   localparam int unsigned ROW_W  = $clog2(ROWS);
   localparam int unsigned TAG_W  = ADDR_W - 2;
   localparam int unsigned WC_W   = $clog2(MAX_WAYS + 1);

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
   } line_type;

   // config registers
   logic       split_ff, wback_ff, walloc_ff;
   logic [3:0] ways_ff, block_ff, sets0_ff, sets1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff  <= 1'b0;
         ways_ff   <= 4'd1;
         block_ff  <= 4'd4;
         sets0_ff  <= 4'd6;
         sets1_ff  <= 4'd6;
         wback_ff  <= 1'b1;
         walloc_ff <= 1'b1;
      end else if (csr_fire) begin
         case (csr_index)
            REG_SPLIT:  split_ff  <= csr_value[0];
            REG_WAYS:   ways_ff   <= csr_value;
            REG_BLOCK:  block_ff  <= csr_value;
            REG_SETS0:  sets0_ff  <= csr_value;
            REG_SETS1:  sets1_ff  <= csr_value;
            REG_WBACK:  wback_ff  <= csr_value[0];
            REG_WALLOC: walloc_ff <= csr_value[0];
            default: ;
         endcase
      end
   end

   // effective configuration
   logic [WC_W-1:0] ways_eff;
   logic [3:0]      bl_eff;
   logic [CNT_W-1:0] wpb;
   always_comb begin
      if (ways_ff == 4'd0)                  ways_eff = WC_W'(1);
      else if (32'(ways_ff) > MAX_WAYS)     ways_eff = WC_W'(MAX_WAYS);
      else                                  ways_eff = WC_W'(ways_ff);
      if (block_ff < 4'd2)      bl_eff = 4'd2;
      else if (block_ff > 4'd8) bl_eff = 4'd8;
      else                      bl_eff = block_ff;
      wpb = CNT_W'((32'd1 << bl_eff) / WORD_BYTES);
   end

   // request capture and index arithmetic
   logic [1:0]        op_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [ROW_W-1:0]  row_in;
   logic [TAG_W-1:0]  tag_in;
   logic              part;
   logic [3:0]        sl_raw, sl;
   logic [ADDR_W-1:0] shifted;
   logic [SET_W-1:0]  set_idx;

   always_comb begin
      part    = (req_opcode != OP_FETCH) && split_ff;
      sl_raw  = part ? sets1_ff : sets0_ff;
      sl      = (32'(sl_raw) > SL_MAX) ? 4'(SL_MAX) : sl_raw;
      shifted = req_address >> bl_eff;
      set_idx = SET_W'(shifted & ((ADDR_W'(1) << sl) - ADDR_W'(1)));
      row_in  = {part, set_idx};
      tag_in  = TAG_W'(shifted >> sl);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff  <= req_opcode;
         row_ff <= row_in;
         tag_ff <= tag_in;
      end
   end

   // set memory: one row holds all ways of a set
   line_type         mem [ROWS][MAX_WAYS];
   line_type         rd_ff [MAX_WAYS];
   logic [ROW_W:0]   sweep_ff;
   logic [ROW_W-1:0] rd_row;
   logic             wr_en;
   line_type         wr_line [MAX_WAYS];
   logic [ROW_W-1:0] wr_row;

   // keep reading the captured row once the request has been taken
   assign rd_row = (ctrl.sweep) ? sweep_ff[ROW_W-1:0] : (ctrl.load ? row_in : row_ff);
   assign stat.sweep_done = (sweep_ff == (ROW_W+1)'(ROWS));

   always_ff @(posedge clock) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (wr_en) mem[wr_row][w] <= wr_line[w];
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         rd_ff[w] <= mem[rd_row][w];
      end
   end

   // sweep pointer; write of cleared row happens in the cycle after its read
   logic             sw_act_ff;
   logic [ROW_W-1:0] sw_row_ff;
   always_ff @(posedge clock) begin
      if (reset || ctrl.sweep_rst) begin
         sweep_ff  <= '0;
         sw_act_ff <= 1'b0;
      end else begin
         sw_act_ff <= ctrl.sweep && !stat.sweep_done;
         if (ctrl.sweep && !stat.sweep_done) sweep_ff <= sweep_ff + 1'b1;
      end
      sw_row_ff <= sweep_ff[ROW_W-1:0];
   end
   logic sw_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) sw_cnt_ff <= 1'b0;
      else       sw_cnt_ff <= ctrl.sweep_cnt && !stat.sweep_done;
   end

   // lookup: compare and victim choice, registered
   logic [MAX_WAYS-1:0] hitv, emptyv;
   logic [WAY_W-1:0]    hit_w, emp_w, lru_w, slot;
   logic                any_hit, any_emp;
   logic [RANK_W-1:0]   best;
   logic                hit_ff, fill_ff, rep_ff, vdirty_ff, bypass_ff;
   logic [WAY_W-1:0]    way_ff;

   always_comb begin
      hit_w = '0; emp_w = '0; lru_w = '0; any_hit = 1'b0; any_emp = 1'b0;
      best  = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         hitv[w]   = (WC_W'(w) < ways_eff) && rd_ff[w].valid && rd_ff[w].tag == tag_ff;
         emptyv[w] = (WC_W'(w) < ways_eff) && !rd_ff[w].valid;
         if (hitv[w])   begin hit_w = WAY_W'(w); any_hit = 1'b1; end
         if (emptyv[w]) begin emp_w = WAY_W'(w); any_emp = 1'b1; end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if ((WC_W'(w) < ways_eff) && rd_ff[w].rank >= best) begin
            best  = rd_ff[w].rank;
            lru_w = WAY_W'(w);
         end
      end
      slot = any_emp ? emp_w : lru_w;
   end

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         hit_ff    <= any_hit;
         bypass_ff <= !any_hit && (op_ff == OP_WRITE) && !walloc_ff;
         fill_ff   <= !any_hit && !((op_ff == OP_WRITE) && !walloc_ff);
         rep_ff    <= !any_hit && !any_emp && !((op_ff == OP_WRITE) && !walloc_ff);
         vdirty_ff <= rd_ff[lru_w].dirty;
         way_ff    <= any_hit ? hit_w : slot;
      end
   end

   // update write data: promote chosen way, or clear all lines of the swept row
   logic [RANK_W-1:0] r_old;
   always_comb begin
      r_old = (hit_ff || rep_ff) ? rd_ff[way_ff].rank : RANK_W'(MAX_WAYS);
      for (int w = 0; w < MAX_WAYS; w++) begin
         wr_line[w] = rd_ff[w];
         if (sw_act_ff) begin
            wr_line[w].valid = 1'b0;
            wr_line[w].dirty = 1'b0;
            wr_line[w].rank  = '0;
         end else if (WAY_W'(w) == way_ff) begin
            wr_line[w].rank = '0;
            if (hit_ff) begin
               if (op_ff == OP_WRITE) wr_line[w].dirty = 1'b1;
            end else begin
               wr_line[w].valid = 1'b1;
               wr_line[w].tag   = tag_ff;
               wr_line[w].dirty = (op_ff == OP_WRITE);
            end
         end else if ((WC_W'(w) < ways_eff) && rd_ff[w].valid && rd_ff[w].rank < r_old) begin
            wr_line[w].rank = rd_ff[w].rank + 1'b1;
         end
      end
      wr_en  = sw_act_ff || (ctrl.update && !bypass_ff);
      wr_row = sw_act_ff ? sw_row_ff : row_ff;
   end

   // counters
   logic [CNT_W-1:0] cnt_ff [N_CNT];
   logic [CNT_W-1:0] inc [N_CNT];
   logic [WC_W-1:0]  ndirty;
   logic             inst, wr;

   function automatic logic [CNT_W-1:0] sat(input logic [CNT_W-1:0] a,
                                            input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   always_comb begin
      inst   = (op_ff == OP_FETCH);
      wr     = (op_ff == OP_WRITE);
      ndirty = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         ndirty = ndirty + WC_W'(rd_ff[w].valid && rd_ff[w].dirty);
      end
      for (int i = 0; i < N_CNT; i++) inc[i] = '0;
      if (ctrl.update) begin
         inc[inst ? C_IACC : C_DACC] = CNT_W'(1);
         if (!hit_ff) inc[inst ? C_IMISS : C_DMISS] = CNT_W'(1);
         if (rep_ff)  inc[inst ? C_IREPL : C_DREPL] = CNT_W'(1);
         if (fill_ff) inc[C_FETCH] = wpb;
         if (bypass_ff || (wr && !wback_ff)) inc[C_COPY] = CNT_W'(1);
         else if (rep_ff && wback_ff && vdirty_ff) inc[C_COPY] = wpb;
      end else if (sw_cnt_ff && wback_ff) begin
         inc[C_COPY] = CNT_W'(ndirty) * wpb;
      end
   end

   logic hitr_ff, repr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_CNT; i++) cnt_ff[i] <= '0;
      end else begin
         for (int i = 0; i < N_CNT; i++) cnt_ff[i] <= sat(cnt_ff[i], inc[i]);
      end
      if (ctrl.load) begin
         hitr_ff <= 1'b0;
         repr_ff <= 1'b0;
      end else if (ctrl.update) begin
         hitr_ff <= hit_ff;
         repr_ff <= rep_ff;
      end
   end

   // result register holds the transaction while the receiver stalls
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;
   always_comb begin
      rsp_in = '0;
      rsp_in[0] = hitr_ff;
      rsp_in[1] = repr_ff;
      for (int i = 0; i < N_CNT; i++) rsp_in[2 + CNT_W*i +: CNT_W] = cnt_ff[i];
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

### rtl/set_assoc_lru_cache_model_unit.sv
// read, write or fetch: the request passes through load, lookup, update and result steps;
// a new request is accepted only once the previous result has been captured
// flush: result after a sweep of all set rows, one set row swept per cycle
// reset and config writes start a clearing pass,
// during which req_tready is low; counters clear on reset only
//------------------------------------------------------------------------------
// set_assoc_lru_cache_model_unit: set associative LRU cache simulator
// Tracks tags and LRU order, reports hit/replace flags and statistics.
//------------------------------------------------------------------------------
`default_nettype none
module set_assoc_lru_cache_model_unit
   import salc_pkg::*;
#(
   parameter int unsigned MAX_WAYS   = 8,
   parameter int unsigned MAX_SETS   = 1024,
   parameter int unsigned WORD_BYTES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // opcode[1:0], address[33:2]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // hit, replaced, inst_accesses, inst_misses, inst_replacements,
   // data_accesses, data_misses, data_replacements, fetch_words, copy_back_words
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_type ctrl;
   stat_type stat;
   logic     req_fire, csr_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign csr_fire  = csr_valid && (csr_index <= REG_WALLOC);

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_flush (req_tdata[1:0] == OP_FLUSH),
      .cfg_fire  (csr_fire),
      .rsp_taken (rsp_tready),
      .stat      (stat),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .ctrl      (ctrl)
   );

   salc_dpath #(
      .MAX_WAYS   (MAX_WAYS),
      .MAX_SETS   (MAX_SETS),
      .WORD_BYTES (WORD_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .req_opcode  (req_tdata[1:0]),
      .req_address (req_tdata[33:2]),
      .csr_fire    (csr_fire),
      .csr_index   (csr_index),
      .csr_value   (csr_data),
      .rsp_data    (rsp_tdata)
   );

endmodule
`default_nettype wire

### rtl/salc_checker.sv
//------------------------------------------------------------------------------
// salc_checker: port checks
// Watches the top-level ports for handshake and ordering slips.
//------------------------------------------------------------------------------
`default_nettype none
module salc_checker
   import salc_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("hit and replaced both set");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown straight after reset");

endmodule

bind set_assoc_lru_cache_model_unit salc_checker u_salc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
